FILE: sv/gapf_pkg.sv
// Shared constants, types and state codes of the global average pooling core.
package gapf_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int AVG_W        = 16;
  localparam int CH_W         = 12;
  localparam int CH_CNT_W     = 13;
  localparam int AREA_CFG_W   = 17;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 17;
  localparam int MAX_AREA_DEF = 65536;
  localparam int MAX_CHANNELS = 4096;
  localparam int CH_REACH     = 1 << CH_W;
  localparam int Q_DEPTH      = 2;

  localparam logic [CH_CNT_W-1:0] CH_LIM = (MAX_CHANNELS < CH_REACH) ?
                                           CH_CNT_W'(MAX_CHANNELS) : CH_CNT_W'(CH_REACH);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_AREA   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = CFG_IDX_W'(1);

  typedef struct packed {
    logic [CH_W-1:0] channel_index;
    logic            tensor_end;
  } tag_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

endpackage

FILE: sv/gapf_front.sv
// Front end: configuration registers, window accumulation and channel counting.
module gapf_front #(
  parameter int MAX_AREA = gapf_pkg::MAX_AREA_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         cfg_valid,
  output logic                                         cfg_ready,
  input  logic [gapf_pkg::CFG_IDX_W-1:0]               cfg_index,
  input  logic [gapf_pkg::CFG_DATA_W-1:0]              cfg_data,
  input  logic                                         in_push,
  output logic                                         in_full,
  input  logic signed [gapf_pkg::SAMPLE_W-1:0]         in_sample,
  input  logic                                         in_tensor_end,
  output logic                                         job_push,
  input  logic                                         job_full,
  output logic signed [gapf_pkg::SAMPLE_W + $clog2(MAX_AREA):0] job_sum,
  output logic [$clog2(MAX_AREA + 1)-1:0]              job_area,
  output gapf_pkg::tag_t                               job_tag
);
  import gapf_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_AREA) + 1;
  localparam int EA_W  = $clog2(MAX_AREA + 1);
  localparam int CMP_W = (AREA_CFG_W > EA_W) ? AREA_CFG_W : EA_W;

  logic [AREA_CFG_W-1:0]   window_area_r, window_area_nxt;
  logic [CH_CNT_W-1:0]     channel_count_r, channel_count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt, sum_add;
  logic [EA_W-1:0]         cnt_r, cnt_nxt, cnt_inc, eff_area;
  logic [CH_W-1:0]         ch_r, ch_nxt;
  logic [CH_CNT_W-1:0]     eff_ch, ch_inc;
  logic                    accept, close;

  assign cfg_ready = 1'b1;
  assign in_full   = job_full;
  assign accept    = in_push && !job_full;

  always_comb begin
    if (window_area_r == '0) begin
      eff_area = EA_W'(1);
    end else if (CMP_W'(window_area_r) > CMP_W'(MAX_AREA)) begin
      eff_area = EA_W'(MAX_AREA);
    end else begin
      eff_area = EA_W'(window_area_r);
    end
    if (channel_count_r == '0) begin
      eff_ch = CH_CNT_W'(1);
    end else if (channel_count_r > CH_LIM) begin
      eff_ch = CH_LIM;
    end else begin
      eff_ch = channel_count_r;
    end
  end

  assign sum_add = sum_r + SUM_W'(in_sample);
  assign cnt_inc = cnt_r + 1'b1;
  assign close   = cnt_inc >= eff_area;
  assign ch_inc  = {1'b0, ch_r} + 1'b1;

  assign job_push              = accept && close;
  assign job_sum               = sum_add;
  assign job_area              = eff_area;
  assign job_tag.channel_index = ch_r;
  assign job_tag.tensor_end    = in_tensor_end;

  always_comb begin
    window_area_nxt   = window_area_r;
    channel_count_nxt = channel_count_r;
    sum_nxt           = sum_r;
    cnt_nxt           = cnt_r;
    ch_nxt            = ch_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_WINDOW_AREA:   window_area_nxt   = AREA_CFG_W'(cfg_data);
        REG_CHANNEL_COUNT: channel_count_nxt = CH_CNT_W'(cfg_data);
        default: ;
      endcase
    end
    if (accept) begin
      if (close) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        if (ch_inc >= eff_ch || in_tensor_end) begin
          ch_nxt = '0;
        end else begin
          ch_nxt = CH_W'(ch_inc);
        end
      end else if (in_tensor_end) begin
        sum_nxt = '0;
        cnt_nxt = '0;
        ch_nxt  = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_area_r   <= AREA_CFG_W'(1);
      channel_count_r <= CH_CNT_W'(1);
      sum_r           <= '0;
      cnt_r           <= '0;
      ch_r            <= '0;
    end else begin
      window_area_r   <= window_area_nxt;
      channel_count_r <= channel_count_nxt;
      sum_r           <= sum_nxt;
      cnt_r           <= cnt_nxt;
      ch_r            <= ch_nxt;
    end
  end

endmodule

FILE: sv/gapf_queue.sv
// Short first-in first-out queue of finished windows between front and back.
module gapf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  output logic         full,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  import gapf_pkg::*;

  localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  logic [W-1:0]  mem_r [Q_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = cnt_r == CW'(Q_DEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

FILE: sv/gapf_div.sv
// Back end: bit-serial signed division of the window sum by its area, and the result register.
module gapf_div #(
  parameter int MAX_AREA = gapf_pkg::MAX_AREA_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         job_valid,
  output logic                                         job_pop,
  input  logic signed [gapf_pkg::SAMPLE_W + $clog2(MAX_AREA):0] job_sum,
  input  logic [$clog2(MAX_AREA + 1)-1:0]              job_area,
  input  gapf_pkg::tag_t                               job_tag,
  output logic                                         out_empty,
  input  logic                                         out_pop,
  output logic signed [gapf_pkg::AVG_W-1:0]            out_average,
  output logic [gapf_pkg::CH_W-1:0]                    out_channel_index,
  output logic                                         out_tensor_end_out
);
  import gapf_pkg::*;

  localparam int SUM_W  = SAMPLE_W + $clog2(MAX_AREA) + 1;
  localparam int EA_W   = $clog2(MAX_AREA + 1);
  localparam int STEP_W = $clog2(SUM_W);

  div_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt, sum_u, mag;
  logic [EA_W-1:0]    rem_r, rem_nxt, div_r, div_nxt;
  logic [EA_W:0]      rem_sh, rem_sub;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               neg_r, neg_nxt, ge;
  tag_t               tag_r, tag_nxt;
  logic [AVG_W-1:0]   avg_r, avg_nxt;
  tag_t               otag_r, otag_nxt;
  logic               ovalid_r, ovalid_nxt;

  assign sum_u   = job_sum;
  assign mag     = job_sum[SUM_W-1] ? (~sum_u + 1'b1) : sum_u;
  assign rem_sh  = {rem_r, quo_r[SUM_W-1]};
  assign rem_sub = rem_sh - {1'b0, div_r};
  assign ge      = rem_sh >= {1'b0, div_r};

  assign out_empty          = !ovalid_r;
  assign out_average        = avg_r;
  assign out_channel_index  = otag_r.channel_index;
  assign out_tensor_end_out = otag_r.tensor_end;

  always_comb begin
    state_nxt  = state_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    step_nxt   = step_r;
    neg_nxt    = neg_r;
    tag_nxt    = tag_r;
    avg_nxt    = avg_r;
    otag_nxt   = otag_r;
    ovalid_nxt = ovalid_r;
    job_pop    = 1'b0;
    if (out_pop && ovalid_r) begin
      ovalid_nxt = 1'b0;
    end
    case (state_r)
      DIV_IDLE: begin
        if (job_valid) begin
          job_pop   = 1'b1;
          quo_nxt   = mag;
          rem_nxt   = '0;
          div_nxt   = job_area;
          neg_nxt   = job_sum[SUM_W-1];
          tag_nxt   = job_tag;
          step_nxt  = STEP_W'(SUM_W - 1);
          state_nxt = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_nxt  = ge ? EA_W'(rem_sub) : EA_W'(rem_sh);
        quo_nxt  = {quo_r[SUM_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = DIV_DONE;
        end
      end
      DIV_DONE: begin
        if (!ovalid_r || out_pop) begin
          avg_nxt    = neg_r ? (~quo_r[AVG_W-1:0] + 1'b1) : quo_r[AVG_W-1:0];
          otag_nxt   = tag_r;
          ovalid_nxt = 1'b1;
          state_nxt  = DIV_IDLE;
        end
      end
      default: state_nxt = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    neg_r  <= neg_nxt;
    tag_r  <= tag_nxt;
    avg_r  <= avg_nxt;
    otag_r <= otag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= DIV_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule

FILE: sv/global_average_pool_forward_core.sv
// Global average pooling core: accumulates channel windows and divides each sum by its area.
//
// Samples enter through a queue-like port: an item is taken when in_push is high and
// in_full is low. Each channel's window_area samples arrive back to back. Results leave
// through out_empty and out_pop: the oldest result sits on the out_ ports while out_empty
// is low and is taken when out_pop is high. Registers are written over the cfg_ port
// (index 0: window area, index 1: channel count); the user must write them only while
// the core is idle, which the block does not enforce. The front end takes one sample
// every cycle while in_full is low. A closing sample places the window sum in a
// two-entry queue; the back end divides it by the area one quotient bit per cycle.
// The divider takes a new window only once the last result is registered, so short
// windows can raise in_full once the queue is full. If the receiver stalls, the finished
// result is held, the divider holds its next quotient and the queue fills, after which
// in_full stays high until out_pop is seen.
// Synchronous reset clears the sums, counters, queue and result valid flag and sets
// both registers to 1.
module global_average_pool_forward_core #(
  parameter int MAX_AREA = gapf_pkg::MAX_AREA_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gapf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [gapf_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic signed [gapf_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_tensor_end,
  output logic                                 out_empty,
  input  logic                                 out_pop,
  output logic signed [gapf_pkg::AVG_W-1:0]    out_average,
  output logic [gapf_pkg::CH_W-1:0]            out_channel_index,
  output logic                                 out_tensor_end_out
);
  import gapf_pkg::*;

  localparam int SUM_W = SAMPLE_W + $clog2(MAX_AREA) + 1;
  localparam int EA_W  = $clog2(MAX_AREA + 1);
  localparam int TAG_W = $bits(tag_t);
  localparam int QW    = SUM_W + EA_W + TAG_W;

  logic                    f_push, q_full, q_empty, q_pop;
  logic signed [SUM_W-1:0] f_sum, q_sum;
  logic [EA_W-1:0]         f_area, q_area;
  tag_t                    f_tag, q_tag;
  logic [QW-1:0]           q_din, q_dout;

  gapf_front #(.MAX_AREA(MAX_AREA)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_sample     (in_sample),
    .in_tensor_end (in_tensor_end),
    .job_push      (f_push),
    .job_full      (q_full),
    .job_sum       (f_sum),
    .job_area      (f_area),
    .job_tag       (f_tag)
  );

  assign q_din = {f_sum, f_area, f_tag};

  gapf_queue #(.W(QW)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .full  (q_full),
    .din   (q_din),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  assign q_sum  = q_dout[QW-1 -: SUM_W];
  assign q_area = q_dout[TAG_W +: EA_W];
  assign q_tag  = q_dout[TAG_W-1:0];

  gapf_div #(.MAX_AREA(MAX_AREA)) u_div (
    .clk                (clk),
    .rst_n              (rst_n),
    .job_valid          (!q_empty),
    .job_pop            (q_pop),
    .job_sum            (q_sum),
    .job_area           (q_area),
    .job_tag            (q_tag),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_average        (out_average),
    .out_channel_index  (out_channel_index),
    .out_tensor_end_out (out_tensor_end_out)
  );

endmodule
